@@ design/imrf_pkg.sv @@
// Package for the masked I2C register file target.
// Holds command codes, FSM state type, sizing constants and the write-mask table.
// No dependencies.
package imrf_pkg;

  localparam int REG_W     = 8;
  localparam int REG_DEPTH = 256;
  localparam int PTR_W     = $clog2(REG_DEPTH);

  typedef enum logic [2:0] {
    CMD_START_WRITE = 3'd0,
    CMD_START_READ  = 3'd1,
    CMD_FINISH      = 3'd2,
    CMD_NACK        = 3'd3,
    CMD_WRITE_BYTE  = 3'd4,
    CMD_READ_BYTE   = 3'd5
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_CMD = 1'b1;

  // Writable bits per register address.
  function automatic logic [REG_W-1:0] wr_mask(input logic [PTR_W-1:0] addr);
    logic [REG_W-1:0] m;
    m = '0;
    case (addr) inside
      8'h11, 8'h32, 8'ha3, 8'ha4, 8'ha7, 8'hb4, 8'hb5, 8'hb8: m = 8'hff;
      8'h33:                                                  m = 8'h81;
      default:                                                m = '0;
    endcase
    return m;
  endfunction

endpackage

@@ design/imrf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module imrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/i2c_masked_register_file_slave_top.sv @@
// Byte-level I2C target: 256-byte register space behind an auto-increment pointer.
// Flow: an accepted request enters the execute state, and its result strobe (out_valid)
//   is registered from there. busy is high for that one execute cycle, so a new request
//   waits out the read-modify-write through the single register RAM.
// Reset (rst_n low, synchronous): pointer 0, pointer capture armed, all registers
//   read as zero at once via per-entry valid bits. Results cannot be stalled.
// Depends on imrf_pkg and imrf_ram.
module i2c_masked_register_file_slave_top #(
  parameter int REG_W     = imrf_pkg::REG_W,
  parameter int REG_DEPTH = imrf_pkg::REG_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  output logic [7:0] out_read_data,
  output logic       out_status
);
  import imrf_pkg::*;

  localparam int AW = $clog2(REG_DEPTH);

  // Control state
  state_t         state_r, state_nxt;
  logic [AW-1:0]  ptr_r, ptr_nxt;
  logic           await_r, await_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [REG_DEPTH-1:0] valid_r;   // entry written since reset

  // Request payload, captured at accept
  cmd_t           cmd_r;
  logic [7:0]     data_r;
  logic           rd_valid_r;      // valid bit of the entry being read

  // Result payload
  logic [7:0]     out_read_data_r, out_read_data_nxt;
  logic           out_status_r, out_status_nxt;

  // RAM side
  logic              accept;
  logic              ram_we;
  logic [REG_W-1:0]  ram_wdata;
  logic [REG_W-1:0]  ram_rdata;
  logic [REG_W-1:0]  old_byte;
  logic [REG_W-1:0]  mask;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Read at the current pointer on accept; data lands for the execute cycle.
  // The write-back in execute always completes before the next accept reads.
  imrf_ram #(
    .WIDTH (REG_W),
    .DEPTH (REG_DEPTH)
  ) u_regs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  // Never-written entries read as the reset value of zero.
  assign old_byte  = rd_valid_r ? ram_rdata : '0;
  assign mask      = wr_mask(ptr_r);
  assign ram_wdata = (old_byte & ~mask) | (data_r & mask);

  always_comb begin
    state_nxt         = state_r;
    ptr_nxt           = ptr_r;
    await_nxt         = await_r;
    out_valid_nxt     = 1'b0;
    out_read_data_nxt = '0;
    out_status_nxt    = STATUS_OK;
    ram_we            = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        case (cmd_r)
          CMD_START_WRITE: begin
            await_nxt = 1'b1;
          end
          CMD_START_READ, CMD_FINISH, CMD_NACK: begin
          end
          CMD_WRITE_BYTE: begin
            if (await_r) begin
              // first data byte after start-of-write is the pointer
              ptr_nxt   = data_r;
              await_nxt = 1'b0;
            end else begin
              // skip the RAM for read-only addresses; the result is unchanged
              ram_we  = (mask != '0);
              ptr_nxt = ptr_r + AW'(1);
            end
          end
          CMD_READ_BYTE: begin
            out_read_data_nxt = old_byte;
            ptr_nxt           = ptr_r + AW'(1);
          end
          default: begin
            out_status_nxt = STATUS_BAD_CMD;
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      await_r     <= 1'b1;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      await_r     <= await_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        valid_r[ptr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= cmd_t'(in_cmd);
      data_r     <= in_data_byte;
      rd_valid_r <= valid_r[ptr_r];
    end
    out_read_data_r <= out_read_data_nxt;
    out_status_r    <= out_status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_status    = out_status_r;

  // Every result strobe follows exactly one execute cycle.
  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_EXEC))
    else $error("result strobe without execute cycle");

  // An accepted request holds off the next one for its execute cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // RAM writes only from execute and only to writable addresses.
  a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_EXEC) && (mask != '0) && !await_r)
    else $error("illegal register write");

  // Non-read results carry zero data.
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(cmd_r != CMD_READ_BYTE)) |-> (out_read_data == '0))
    else $error("read data on non-read result");

endmodule
